### rtl/one_wire_master_unit_defines.svh
// ----------------------------------------------------------------------------
// one_wire_master_unit_defines.svh
// Assertion macros for the one-wire bus master. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_MASTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define OWM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one-wire master implication check failed");
// Next-cycle implication.
`define OWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one-wire master next-cycle check failed");
`else
`define OWM_ASSERT_IMPLY(lbl, ante, cons)
`define OWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// Shared constants, codes and types of the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int CFG_W           = 10;
	localparam int SLOT_W          = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int TIMER_WIDTH_DEF = 10;
	localparam int PHASE_W         = 4;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_HIGH  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_RST_RECOV = 4'd4;
	localparam logic [PHASE_W-1:0] PH_SLOT_LOW  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WR_HOLD   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RD_WAIT   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_RD_HOLD   = 4'd8;

	// command codes
	localparam logic [1:0] OP_RESET = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_HIGH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_START   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD    = 3'd6;

	// register reset values
	localparam logic [CFG_W-1:0]  RST_RESET_HIGH  = 10'd20;
	localparam logic [CFG_W-1:0]  RST_RESET_LOW   = 10'd480;
	localparam logic [CFG_W-1:0]  RST_PRESENCE    = 10'd60;
	localparam logic [CFG_W-1:0]  RST_RECOVERY    = 10'd420;
	localparam logic [SLOT_W-1:0] RST_SLOT_START  = 4'd2;
	localparam logic [SLOT_W-1:0] RST_READ_SAMPLE = 4'd2;
	localparam logic [CFG_W-1:0]  RST_SLOT_HOLD   = 10'd60;

	typedef struct packed {
		logic [CFG_W-1:0]  reset_high_ticks;
		logic [CFG_W-1:0]  reset_low_ticks;
		logic [CFG_W-1:0]  presence_wait_ticks;
		logic [CFG_W-1:0]  reset_recovery_ticks;
		logic [SLOT_W-1:0] slot_start_ticks;
		logic [SLOT_W-1:0] read_sample_ticks;
		logic [CFG_W-1:0]  slot_hold_ticks;
	} cfg_t;

	// phase timer status
	typedef struct packed {
		logic release_line;
		logic last;
	} ctl_t;

	typedef struct packed {
		logic       line_release;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       no_device;
	} res_t;

endpackage

### rtl/owm_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_timer
// Selects the phase length and line drive for the current phase and flags the
// last tick of the phase.
// ----------------------------------------------------------------------------
module owm_timer import owm_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic [PHASE_W-1:0]     phase,
	input  logic [TIMER_WIDTH-1:0] tick_count,
	input  logic                   hold_bit,
	input  cfg_t                   cfg,
	output ctl_t                   ctl
);

	localparam int CW = ((TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W) + 1;

	logic [CFG_W-1:0] raw;
	logic [CW-1:0]    ext;
	logic [CW-1:0]    lim;
	logic [CW-1:0]    len;
	logic [CW-1:0]    tick_inc;

	always_comb begin
		ctl.release_line = 1'b1;
		raw = cfg.slot_hold_ticks;
		case (phase)
			PH_RST_HIGH:  raw = cfg.reset_high_ticks;
			PH_RST_LOW: begin
				raw = cfg.reset_low_ticks;
				ctl.release_line = 1'b0;
			end
			PH_RST_WAIT:  raw = cfg.presence_wait_ticks;
			PH_RST_RECOV: raw = cfg.reset_recovery_ticks;
			PH_SLOT_LOW: begin
				raw = CFG_W'(cfg.slot_start_ticks);
				ctl.release_line = 1'b0;
			end
			PH_WR_HOLD: begin
				raw = cfg.slot_hold_ticks;
				ctl.release_line = hold_bit;
			end
			PH_RD_WAIT:   raw = CFG_W'(cfg.read_sample_ticks);
			default:      raw = cfg.slot_hold_ticks;
		endcase

		// zero acts as one tick; long lengths clip to the timer range
		ext = CW'(raw);
		lim = CW'(1) << TIMER_WIDTH;
		if (raw == '0) begin
			len = CW'(1);
		end else if (ext > lim) begin
			len = lim;
		end else begin
			len = ext;
		end
		tick_inc = CW'(tick_count) + CW'(1);
		ctl.last = (tick_inc >= len);
	end

endmodule

### rtl/owm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer state and one-tick next-state logic. Produces the outputs of
// each tick from the registered input item.
// ----------------------------------------------------------------------------
module owm_core import owm_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic       cmd_valid,
	input  logic [1:0] operation,
	input  logic [7:0] write_data,
	input  logic       line_level,
	input  cfg_t       cfg,
	output res_t       res
);

	logic [PHASE_W-1:0]     phase_q, ph0, phase_nx;
	logic [TIMER_WIDTH-1:0] tick_q, tick0, tick_nx;
	logic [2:0]             bit_q, bit0, bit_nx;
	logic [7:0]             shift_q, shift0, shift_nx;
	logic [1:0]             op_q, op0;
	logic                   presence_q, presence_nx;
	logic [7:0]             latch_q, latch_nx;
	logic                   start;
	logic                   slot_end;
	logic                   done;
	ctl_t                   ctl;

	// a command is taken only while idle; operation 3 is dropped
	always_comb begin
		start  = (phase_q == PH_IDLE) && cmd_valid && (operation != OP_NONE);
		ph0    = phase_q;
		tick0  = tick_q;
		bit0   = bit_q;
		shift0 = shift_q;
		op0    = op_q;
		if (start) begin
			op0   = operation;
			tick0 = '0;
			bit0  = '0;
			if (operation == OP_RESET) begin
				ph0 = PH_RST_HIGH;
			end else begin
				shift0 = (operation == OP_WRITE) ? write_data : 8'h00;
				ph0    = PH_SLOT_LOW;
			end
		end
	end

	owm_timer #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_timer (
		.phase      (ph0),
		.tick_count (tick0),
		.hold_bit   (shift0[0]),
		.cfg        (cfg),
		.ctl        (ctl)
	);

	always_comb begin
		phase_nx    = ph0;
		tick_nx     = tick0;
		bit_nx      = bit0;
		shift_nx    = shift0;
		presence_nx = presence_q;
		latch_nx    = latch_q;
		slot_end    = 1'b0;
		done        = 1'b0;
		if (ph0 != PH_IDLE) begin
			if (!ctl.last) begin
				tick_nx = tick0 + TIMER_WIDTH'(1);
			end else begin
				tick_nx = '0;
				case (ph0)
					PH_RST_HIGH: phase_nx = PH_RST_LOW;
					PH_RST_LOW:  phase_nx = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_nx = line_level;
						phase_nx    = PH_RST_RECOV;
					end
					PH_RST_RECOV: begin
						done     = 1'b1;
						phase_nx = PH_IDLE;
					end
					PH_SLOT_LOW: phase_nx = (op0 == OP_WRITE) ? PH_WR_HOLD : PH_RD_WAIT;
					PH_WR_HOLD: begin
						shift_nx = {1'b0, shift0[7:1]};
						slot_end = 1'b1;
					end
					PH_RD_WAIT: begin
						shift_nx = {line_level, shift0[7:1]};
						phase_nx = PH_RD_HOLD;
					end
					default: slot_end = 1'b1;
				endcase
				if (slot_end) begin
					if (bit0 == 3'd7) begin
						done     = 1'b1;
						phase_nx = PH_IDLE;
						bit_nx   = '0;
						if (op0 == OP_READ) begin
							latch_nx = shift_nx;
						end
					end else begin
						bit_nx   = bit0 + 3'd1;
						phase_nx = PH_SLOT_LOW;
					end
				end
			end
		end
	end

	always_comb begin
		res.line_release = (ph0 == PH_IDLE) ? 1'b1 : ctl.release_line;
		res.busy         = (ph0 != PH_IDLE);
		res.done         = done;
		res.read_data    = latch_nx;
		res.no_device    = presence_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			op_q       <= OP_RESET;
			presence_q <= 1'b1;
			latch_q    <= '0;
		end else if (step_en) begin
			phase_q    <= phase_nx;
			tick_q     <= tick_nx;
			bit_q      <= bit_nx;
			shift_q    <= shift_nx;
			op_q       <= op0;
			presence_q <= presence_nx;
			latch_q    <= latch_nx;
		end
	end

endmodule

### rtl/one_wire_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_unit
// One-wire bus master stepped one bus tick per transaction: reset/presence,
// write byte and read byte commands with programmable phase lengths.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | cmd_valid, operation, write_data, line_level
//  out     | out_valid / out_ready| line_release, busy_res, done_res,
//          |                      | read_data, no_device
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One tick per cycle unless the result side stalls: input register, one pass
//  of sequencer logic, result register.
//  The sequencer state advances when the input stage moves into the result
//  register, so a stall on the result side also holds the sequencer state.
//  Reset (arst_n) idles the bus and loads default lengths; the result register is not reset.
//  A stalled result holds the input stage; one more tick waits in it.
// ----------------------------------------------------------------------------
`include "one_wire_master_unit_defines.svh"

module one_wire_master_unit import owm_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd_valid,
	input  logic [1:0]           operation,
	input  logic [7:0]           write_data,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 line_release,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [7:0]           read_data,
	output logic                 no_device,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic       valid_s1;
	logic       cmd_valid_s1;
	logic [1:0] operation_s1;
	logic [7:0] write_data_s1;
	logic       line_level_s1;
	logic       advance;
	logic       out_valid_q;
	res_t       res_nx, res_q;
	cfg_t       cfg_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_valid_s1  <= cmd_valid;
			operation_s1  <= operation;
			write_data_s1 <= write_data;
			line_level_s1 <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_high_ticks     <= RST_RESET_HIGH;
			cfg_q.reset_low_ticks      <= RST_RESET_LOW;
			cfg_q.presence_wait_ticks  <= RST_PRESENCE;
			cfg_q.reset_recovery_ticks <= RST_RECOVERY;
			cfg_q.slot_start_ticks     <= RST_SLOT_START;
			cfg_q.read_sample_ticks    <= RST_READ_SAMPLE;
			cfg_q.slot_hold_ticks      <= RST_SLOT_HOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_HIGH:  cfg_q.reset_high_ticks     <= cfg_data;
				REG_RESET_LOW:   cfg_q.reset_low_ticks      <= cfg_data;
				REG_PRESENCE:    cfg_q.presence_wait_ticks  <= cfg_data;
				REG_RECOVERY:    cfg_q.reset_recovery_ticks <= cfg_data;
				REG_SLOT_START:  cfg_q.slot_start_ticks     <= cfg_data[SLOT_W-1:0];
				REG_READ_SAMPLE: cfg_q.read_sample_ticks    <= cfg_data[SLOT_W-1:0];
				REG_SLOT_HOLD:   cfg_q.slot_hold_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	owm_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.cmd_valid  (cmd_valid_s1),
		.operation  (operation_s1),
		.write_data (write_data_s1),
		.line_level (line_level_s1),
		.cfg        (cfg_q),
		.res        (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_release = res_q.line_release;
	assign busy_res     = res_q.busy;
	assign done_res     = res_q.done;
	assign read_data    = res_q.read_data;
	assign no_device    = res_q.no_device;

	// input side only stalls behind a held result
	`OWM_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready)
	// a finishing tick belongs to a command
	`OWM_ASSERT_IMPLY(a_done_busy, out_valid && done_res, busy_res)
	// the line is never pulled low while idle
	`OWM_ASSERT_IMPLY(a_idle_release, out_valid && !busy_res, line_release)
	// a stalled input stage is still there next cycle
	`OWM_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1)

endmodule
